// ----- src/rws_pkg.sv -----
// Shared constants for the roulette wheel selector.
// Field widths, command and status codes and the register map.
// No dependencies.
package rws_pkg;

    localparam int SHARE_W         = 16;
    localparam int INDEX_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int RANDOM_W        = 32;
    localparam int DEF_MAX_ENTRIES = 1024;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Register map: one register, selected by paddr[2].
    localparam int                 PADDR_W         = 3;
    localparam logic               REG_ENTRY_COUNT = 1'b0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_ZERO_TOTAL = 1'b1;

endpackage

// ----- src/rws_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rws_mod_unit.sv -----
// Restoring remainder unit: reduces the random word modulo the total share,
// one dividend bit per cycle. Depends on rws_pkg.
module rws_mod_unit
    import rws_pkg::*;
#(
    parameter int TOTAL_W = 27
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [RANDOM_W-1:0] dividend,
    input  logic [TOTAL_W-1:0]  divisor,
    output logic                done,
    output logic [TOTAL_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(RANDOM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RANDOM_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RANDOM_W-1:0] dvd_reg, dvd_next;
    logic [TOTAL_W-1:0]  dsr_reg, dsr_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [TOTAL_W:0]    trial;
    logic [TOTAL_W:0]    diff;

    always_comb begin
        trial     = {rem_reg, dvd_reg[RANDOM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so it fits back.
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[TOTAL_W-1:0];
            end else begin
                rem_next = trial[TOTAL_W-1:0];
            end
            dvd_next = {dvd_reg[RANDOM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/roulette_wheel_selector_top.sv -----
// Roulette wheel selector. A write beat is answered in the cycle after it is accepted.
// A draw over n entries sums the shares with one share-store read per cycle,
// reduces the random word in the remainder unit, then walks with one read per cycle.
// One item is in work at a time; the single read port of the store sets this.
// After reset a clearing pass zeroes the store, during which no item is
// accepted; configuration writes are taken throughout.
module roulette_wheel_selector_top
    import rws_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [INDEX_W-1:0]  s_entry_index,
    input  logic [SHARE_W-1:0]  s_share_value,
    input  logic [RANDOM_W-1:0] s_random_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [INDEX_W-1:0]  m_selected_index,
    output logic                m_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = ($clog2(MAX_ENTRIES + 1) > COUNT_W) ?
                        $clog2(MAX_ENTRIES + 1) : COUNT_W;
    localparam int TW = SHARE_W + $clog2(MAX_ENTRIES + 1);

    localparam logic [CW-1:0] MAX_N     = CW'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       data_idx_reg, data_idx_next;
    logic                pend_reg;
    logic [TW-1:0]       total_reg, total_next;
    logic [TW-1:0]       target_reg, target_next;
    logic [TW-1:0]       running_reg, running_next;
    logic [RANDOM_W-1:0] rnd_reg, rnd_next;
    logic [CW-1:0]       pick_reg, pick_next;
    logic                err_reg, err_next;

    logic                m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;
    logic                m_status_reg, m_status_next;

    logic                cfg_write;
    logic                accept;
    logic                issue;
    logic                mod_start;
    logic                mod_done;
    logic [TW-1:0]       mod_rem;
    logic [TW-1:0]       walk_sum;
    logic [CW-1:0]       count_ext;
    logic [CW-1:0]       index_ext;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SHARE_W-1:0]  ram_wdata;
    logic [SHARE_W-1:0]  ram_rdata;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_write && paddr[2] == REG_ENTRY_COUNT) begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {{(32-COUNT_W){1'b0}}, count_reg} : 32'd0;

    // Handshake and control.
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign issue     = ((state_reg == ST_SUM) || (state_reg == ST_WALK)) && (addr_reg < n_reg);
    assign count_ext = CW'(count_reg);
    assign index_ext = CW'(s_entry_index);
    assign walk_sum  = running_reg + TW'(ram_rdata);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        n_next        = n_reg;
        addr_next     = addr_reg;
        data_idx_next = data_idx_reg;
        total_next    = total_reg;
        target_next   = target_reg;
        running_next  = running_reg;
        rnd_next      = rnd_reg;
        pick_next     = pick_reg;
        err_next      = err_reg;
        mod_start     = 1'b0;
        m_valid_next  = m_valid_reg;
        m_index_next  = m_index_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(s_entry_index);
        ram_wdata     = s_share_value;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (issue) begin
            addr_next     = addr_reg + 1'b1;
            data_idx_next = addr_reg;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_WRITE) begin
                        // Writes beyond the table are dropped but still answered.
                        ram_we        = index_ext < MAX_N;
                        m_valid_next  = 1'b1;
                        m_index_next  = '0;
                        m_status_next = STATUS_OK;
                    end else begin
                        n_next     = (count_ext > MAX_N) ? MAX_N : count_ext;
                        addr_next  = '0;
                        total_next = '0;
                        rnd_next   = s_random_value;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (pend_reg) begin
                    total_next = total_reg + TW'(ram_rdata);
                end
                if (addr_reg == n_reg && !pend_reg) begin
                    if (total_reg == '0) begin
                        err_next   = 1'b1;
                        pick_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    target_next  = mod_rem;
                    running_next = '0;
                    addr_next    = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                // The target lies below the total, so some entry always ends the walk.
                if (pend_reg) begin
                    running_next = walk_sum;
                    if (walk_sum > target_reg) begin
                        err_next   = 1'b0;
                        pick_next  = data_idx_reg;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_index_next  = INDEX_W'(pick_reg);
                    m_status_next = err_reg ? STATUS_ZERO_TOTAL : STATUS_OK;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= issue;
            m_valid_reg  <= m_valid_next;
        end
        n_reg        <= n_next;
        addr_reg     <= addr_next;
        data_idx_reg <= data_idx_next;
        total_reg    <= total_next;
        target_reg   <= target_next;
        running_reg  <= running_next;
        rnd_reg      <= rnd_next;
        pick_reg     <= pick_next;
        err_reg      <= err_next;
        m_index_reg  <= m_index_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_index = m_index_reg;
    assign m_status         = m_status_reg;

    rws_ram #(
        .WIDTH (SHARE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_share_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (issue),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    rws_mod_unit #(
        .TOTAL_W (TW)
    ) u_mod_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !(s_valid && s_ready))
        else $error("input beat accepted while a draw or clearing pass is running");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (total_reg != '0))
        else $error("remainder unit started with a zero total");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (running_reg <= target_reg))
        else $error("running sum passed the target without ending the walk");

    a_error_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_ZERO_TOTAL) |-> (m_selected_index == '0))
        else $error("failed draw returned a non-zero index");
`endif

endmodule
